// File: hdl/assert_macros.svh
// Assertion macros of the PWM meter, included by its top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PFDM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define PFDM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/pfdm_pkg.sv
// Shared widths, constants and types of the PWM frequency and duty meter.
package pfdm_pkg;

  localparam int COUNT_W    = 32;
  localparam int CLK_W      = 30;
  localparam int FREQ_W     = 16;
  localparam int DUTY_W     = 7;
  localparam int SUM_W      = COUNT_W + 1;
  localparam int DIV_W      = (COUNT_W + DUTY_W > CLK_W) ? COUNT_W + DUTY_W : CLK_W;
  localparam int STEP_W     = $clog2(DIV_W);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CLK_W-1:0]   CLOCK_HZ_RESET = CLK_W'(12000000);
  localparam logic [FREQ_W-1:0]  FREQ_MAX       = '1;
  localparam logic [DUTY_W-1:0]  PERCENT        = DUTY_W'(100);
  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

  typedef struct packed {
    logic [COUNT_W-1:0] high_ticks;
    logic [COUNT_W-1:0] low_ticks;
  } pfdm_meas_t;

endpackage

// File: hdl/pfdm_channels.sv
// Valid/ready channel interfaces of the PWM meter: pulse samples in, measurements out.
interface pfdm_in_if import pfdm_pkg::*; ();
  logic valid;
  logic ready;
  logic pulse_level;

  modport source (output valid, output pulse_level, input ready);
  modport sink   (input valid, input pulse_level, output ready);
endinterface

interface pfdm_out_if import pfdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_hz;
  logic [DUTY_W-1:0] duty_percent;
  logic              period_zero;

  modport source (output valid, output freq_hz, output duty_percent, output period_zero,
                  input ready);
  modport sink   (input valid, input freq_hz, input duty_percent, input period_zero,
                  output ready);
endinterface

// File: hdl/pfdm_front.sv
// Front end: edge detection, interval counting and measurement push into the queue.
module pfdm_front import pfdm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pfdm_in_if.sink    in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output pfdm_meas_t push_data
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  logic               prev_level_r, prev_level_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [COUNT_W-1:0] tick_count_r, tick_count_nxt;
  logic [COUNT_W-1:0] high_ticks_r, high_ticks_nxt;
  logic [COUNT_W-1:0] low_ticks_r, low_ticks_nxt;
  logic               high_known_r, high_known_nxt;
  logic               low_known_r, low_known_nxt;
  logic               accept;
  logic               rising;
  logic               falling;
  logic               updated;
  logic [COUNT_W-1:0] count_inc;

  assign in_ch.ready = push_ready;

  always_comb begin
    accept    = in_ch.valid && in_ch.ready;
    rising    = !prev_level_r && in_ch.pulse_level;
    falling   = prev_level_r && !in_ch.pulse_level;
    count_inc = tick_count_r + COUNT_W'(tick_count_r != COUNT_MAX);

    prev_level_nxt = prev_level_r;
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    high_ticks_nxt = high_ticks_r;
    low_ticks_nxt  = low_ticks_r;
    high_known_nxt = high_known_r;
    low_known_nxt  = low_known_r;
    updated        = 1'b0;

    if (accept) begin
      prev_level_nxt = in_ch.pulse_level;
      unique case (phase_r)
        PH_HIGH: begin
          tick_count_nxt = count_inc;
          if (falling) begin
            high_ticks_nxt = count_inc;
            high_known_nxt = 1'b1;
            tick_count_nxt = '0;
            phase_nxt      = PH_LOW;
            updated        = 1'b1;
          end
        end
        PH_LOW: begin
          tick_count_nxt = count_inc;
          if (rising) begin
            low_ticks_nxt = count_inc;
            low_known_nxt = 1'b1;
            tick_count_nxt = '0;
            phase_nxt      = PH_HIGH;
            updated        = 1'b1;
          end
        end
        default: begin
          if (rising) begin
            tick_count_nxt = '0;
            phase_nxt      = PH_HIGH;
          end
        end
      endcase
    end

    push_valid           = updated && high_known_nxt && low_known_nxt;
    push_data.high_ticks = high_ticks_nxt;
    push_data.low_ticks  = low_ticks_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      phase_r      <= PH_WAIT;
      tick_count_r <= '0;
      high_ticks_r <= '0;
      low_ticks_r  <= '0;
      high_known_r <= 1'b0;
      low_known_r  <= 1'b0;
    end else begin
      prev_level_r <= prev_level_nxt;
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      high_ticks_r <= high_ticks_nxt;
      low_ticks_r  <= low_ticks_nxt;
      high_known_r <= high_known_nxt;
      low_known_r  <= low_known_nxt;
    end
  end

endmodule

// File: hdl/pfdm_fifo.sv
// Short measurement queue between the front end and the divider back end.
module pfdm_fifo import pfdm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  pfdm_meas_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output pfdm_meas_t pop_data
);

  pfdm_meas_t            mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/pfdm_back.sv
// Back end: bit-serial division for frequency and duty, and the output register.
module pfdm_back import pfdm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CLK_W-1:0] clock_hz,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  pfdm_meas_t       pop_data,
  pfdm_out_if.source       out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]         state_r;
  logic [STEP_W-1:0]  step_r;
  logic [COUNT_W-1:0] hi_r;
  logic [SUM_W-1:0]   sum_r;
  logic               zero_r;
  logic [SUM_W-1:0]   rem_f_r, rem_d_r;
  logic [DIV_W-1:0]   dvd_f_r, dvd_d_r;
  logic               out_valid_r;
  logic [FREQ_W-1:0]  out_freq_r;
  logic [DUTY_W-1:0]  out_duty_r;
  logic               out_zero_r;

  logic [SUM_W:0]     shf_f, shf_d, diff_f, diff_d, sum_ext;
  logic               ge_f, ge_d;
  logic [SUM_W-1:0]   rem_f_step, rem_d_step;
  logic [DIV_W-1:0]   dvd_f_step, dvd_d_step;
  logic [FREQ_W-1:0]  freq_q;
  logic               out_free;
  logic               out_load;

  always_comb begin
    sum_ext    = {1'b0, sum_r};
    shf_f      = {rem_f_r, dvd_f_r[DIV_W-1]};
    shf_d      = {rem_d_r, dvd_d_r[DIV_W-1]};
    ge_f       = (shf_f >= sum_ext);
    ge_d       = (shf_d >= sum_ext);
    diff_f     = shf_f - sum_ext;
    diff_d     = shf_d - sum_ext;
    rem_f_step = ge_f ? diff_f[SUM_W-1:0] : shf_f[SUM_W-1:0];
    rem_d_step = ge_d ? diff_d[SUM_W-1:0] : shf_d[SUM_W-1:0];
    dvd_f_step = {dvd_f_r[DIV_W-2:0], ge_f};
    dvd_d_step = {dvd_d_r[DIV_W-2:0], ge_d};
    freq_q     = (|dvd_f_r[DIV_W-1:FREQ_W]) ? FREQ_MAX : dvd_f_r[FREQ_W-1:0];
    out_free   = !out_valid_r || out_ch.ready;
    out_load   = (state_r == ST_OUT) && out_free;
  end

  assign pop_ready           = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.freq_hz      = out_freq_r;
  assign out_ch.duty_percent = out_duty_r;
  assign out_ch.period_zero  = out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          step_r  <= STEP_W'(DIV_W - 1);
          state_r <= (sum_r == '0) ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (step_r == '0) begin
            state_r <= ST_OUT;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        hi_r  <= pop_data.high_ticks;
        sum_r <= SUM_W'(pop_data.high_ticks) + SUM_W'(pop_data.low_ticks);
      end
      ST_PREP: begin
        zero_r  <= (sum_r == '0);
        rem_f_r <= '0;
        rem_d_r <= '0;
        dvd_f_r <= DIV_W'(clock_hz);
        dvd_d_r <= DIV_W'(hi_r) * DIV_W'(PERCENT);
      end
      ST_DIV: begin
        rem_f_r <= rem_f_step;
        rem_d_r <= rem_d_step;
        dvd_f_r <= dvd_f_step;
        dvd_d_r <= dvd_d_step;
      end
      ST_OUT: begin
        if (out_free) begin
          out_freq_r <= zero_r ? '0 : freq_q;
          out_duty_r <= zero_r ? '0 : dvd_d_r[DUTY_W-1:0];
          out_zero_r <= zero_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/pwm_frequency_duty_meter.sv
// Top level of the PWM frequency and duty-cycle meter.
//
// in_ch carries one sample of the measured signal per transfer (pulse_level).
// The first rising edge starts timing; each later edge that closes the high
// or the low part updates that time, and once both are known such an edge
// produces one transfer on out_ch: freq_hz = clock_hz / period (saturated at
// 65535), duty_percent = 100 * high / period, period_zero for an empty period.
// The user writes clock_hz through cfg_wr_en / cfg_wr_data only while the
// block is idle; the block does not enforce it. in_ch takes one sample per
// cycle while the two-entry measurement queue has room. The back end takes a
// measurement through prep, a 39-step bit-serial divide and output, and pops
// the next only when idle again. A stalled out_ch holds the result register;
// the divider still finishes the next measurement, then the queue fills and
// in_ch.ready drops. Reset clears the edge tracker, the queue and the output
// valid flag and loads clock_hz with 12000000.
`include "assert_macros.svh"

module pwm_frequency_duty_meter import pfdm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  pfdm_in_if.sink          in_ch,
  pfdm_out_if.source       out_ch,
  input  logic             cfg_wr_en,
  input  logic [CLK_W-1:0] cfg_wr_data
);

  logic [CLK_W-1:0] clock_hz_r;
  logic             push_valid;
  logic             push_ready;
  pfdm_meas_t       push_data;
  logic             pop_valid;
  logic             pop_ready;
  pfdm_meas_t       pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_HZ_RESET;
    end else if (cfg_wr_en) begin
      clock_hz_r <= cfg_wr_data;
    end
  end

  pfdm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pfdm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pfdm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clock_hz  (clock_hz_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

  `PFDM_ASSERT(a_no_push_when_full, !(push_valid && !push_ready), "measurement lost at full queue")
  `PFDM_ASSERT_IMPL(a_duty_range, out_ch.valid, out_ch.duty_percent <= PERCENT, "duty above 100")
  `PFDM_ASSERT_IMPL(a_zero_period, out_ch.valid && out_ch.period_zero, out_ch.freq_hz == '0 && out_ch.duty_percent == '0, "nonzero result for empty period")

endmodule
